### src/idat_pkg.sv
// ----------------------------------------------------------------------------
// idat_pkg: shared types and constants of the ignition dwell/advance timer
// Item layouts, event and register codes, reset values and the dwell and
// advance table functions.
// ----------------------------------------------------------------------------
package idat_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    // ADC window and table shape
    localparam logic [7:0]  ADC_LOW     = 8'd114;
    localparam logic [7:0]  ADC_HIGH    = 8'd214;
    localparam logic [15:0] DWELL_START = 16'd600;
    localparam logic [15:0] TABLE_STEP  = 16'd25;

    // floor(p / 100) == (p * SCALE_RECIP) >> SCALE_SHIFT for p up to 6300
    localparam int unsigned SCALE_RECIP = 5243;
    localparam int unsigned SCALE_SHIFT = 19;

    // Register reset values
    localparam logic [15:0] RST_SHORT_LIMIT = 16'd1209;
    localparam logic [15:0] RST_LONG_LIMIT  = 16'd62500;
    localparam logic [15:0] RST_BASE_DELAY  = 16'd400;
    localparam logic [15:0] RST_BURN_FLOOR  = 16'd100;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_BATTERY = 2'd2,
        OP_VACUUM  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_LIMIT = 3'd0,
        CFG_LONG_LIMIT  = 3'd1,
        CFG_BASE_DELAY  = 3'd2,
        CFG_BURN_FLOOR  = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op        op;
        logic [7:0] sample;
    } t_in_item;

    typedef struct packed {
        logic        coil_drive;
        logic        cycle_valid;
        logic [15:0] captured_cycle;
        logic [15:0] spark_time;
        logic [15:0] charge_time;
    } t_out_item;

    // Dwell shortens as the battery voltage rises.
    function automatic logic [15:0] dwell_entry(input logic [15:0] idx);
        return DWELL_START - 16'(TABLE_STEP * idx);
    endfunction

    // Advance grows with manifold vacuum.
    function automatic logic [15:0] advance_entry(input logic [15:0] idx);
        return 16'(TABLE_STEP * idx);
    endfunction

endpackage

### src/idat_scale.sv
// ----------------------------------------------------------------------------
// idat_scale: ADC sample to table index
// Clamp the reading to the ADC window and scale it to 0..TABLE_ENTRIES-1.
// ----------------------------------------------------------------------------
module idat_scale #(
    parameter int unsigned TABLE_ENTRIES = idat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic [7:0]                         i_sample,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   o_index
);
    import idat_pkg::*;

    localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int unsigned SCALE_MUL = (TABLE_ENTRIES - 1) * SCALE_RECIP;
    localparam int unsigned PROD_W    = 26;

    logic [7:0]        clamped;
    logic [6:0]        offset;
    logic [PROD_W-1:0] prod;

    always_comb begin
        if (i_sample < ADC_LOW) begin
            clamped = ADC_LOW;
        end else if (i_sample > ADC_HIGH) begin
            clamped = ADC_HIGH;
        end else begin
            clamped = i_sample;
        end
        offset  = 7'(clamped - ADC_LOW);
        // one constant multiply covers both the (N-1) scale and the /100
        prod    = PROD_W'(offset) * PROD_W'(SCALE_MUL);
        o_index = prod[SCALE_SHIFT +: IDX_W];
    end

endmodule

### src/ignition_dwell_advance_timer.sv
// ----------------------------------------------------------------------------
// ignition_dwell_advance_timer: coil dwell and spark advance timer
// An accepted item is held in the input register, then its result is loaded into the result register.
// Throughput: one item per cycle, back to back, limited only by output stall.
// Reset (synchronous, active low): counter stopped at zero, coil off, compares
// disarmed, points and indices zero, registers at their defaults.
// Configuration writes are always ready and take effect at the next edge.
// ----------------------------------------------------------------------------
module ignition_dwell_advance_timer #(
    parameter int unsigned TABLE_ENTRIES = idat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // event items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  idat_pkg::t_in_item                 i_in_data,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output idat_pkg::t_out_item                o_out_data,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [idat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import idat_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    // configuration registers
    logic [15:0] r_short_limit, r_long_limit, r_base_delay, r_burn_floor;

    // input stage
    logic       r_in_valid;
    t_in_item   r_in_data;

    // timer state
    logic [15:0]      r_counter, n_counter;
    logic             r_counting, n_counting;
    logic             r_armed, n_armed;
    logic             r_coil, n_coil;
    logic [15:0]      r_spark, n_spark;
    logic [15:0]      r_charge, n_charge;
    logic [15:0]      r_capture, n_capture;
    logic [IDX_W-1:0] r_bat_idx, n_bat_idx;
    logic [IDX_W-1:0] r_vac_idx, n_vac_idx;

    // result stage
    logic       r_out_valid;
    t_out_item  r_out_data;

    logic             advance;
    logic             fire;
    logic [IDX_W-1:0] sample_idx;
    logic [15:0]      cnt_inc;
    logic             in_window;
    logic [15:0]      spark_calc;
    logic [15:0]      charge_calc;

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or taken; the input
    // register moves into it whenever it does. Stall upstream only while
    // an item waits in the input register and cannot move on.
    // ------------------------------------------------------------------
    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers; unknown indices drop silently.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit <= RST_SHORT_LIMIT;
            r_long_limit  <= RST_LONG_LIMIT;
            r_base_delay  <= RST_BASE_DELAY;
            r_burn_floor  <= RST_BURN_FLOOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_LIMIT: r_short_limit <= i_cfg_data;
                CFG_LONG_LIMIT:  r_long_limit  <= i_cfg_data;
                CFG_BASE_DELAY:  r_base_delay  <= i_cfg_data;
                CFG_BURN_FLOOR:  r_burn_floor  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared sample scaler: battery and vacuum use the same clamp and scale.
    idat_scale #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_scale (
        .i_sample (r_in_data.sample),
        .o_index  (sample_idx)
    );

    // ------------------------------------------------------------------
    // Trigger arithmetic: spark = cycle - base - advance,
    // charge = spark - dwell, floored at the burn time as a signed value.
    // ------------------------------------------------------------------
    always_comb begin
        in_window   = (r_counter > r_short_limit) && (r_counter < r_long_limit);
        spark_calc  = r_counter - r_base_delay - advance_entry(16'(r_vac_idx));
        charge_calc = spark_calc - dwell_entry(16'(r_bat_idx));
        if ($signed(charge_calc) < $signed({1'b0, r_burn_floor})) begin
            charge_calc = r_burn_floor;
        end
    end

    assign cnt_inc = r_counter + 16'd1;

    // ------------------------------------------------------------------
    // Event processing: next state for the item in the input register.
    // ------------------------------------------------------------------
    always_comb begin
        n_counter  = r_counter;
        n_counting = r_counting;
        n_armed    = r_armed;
        n_coil     = r_coil;
        n_spark    = r_spark;
        n_charge   = r_charge;
        n_capture  = r_capture;
        n_bat_idx  = r_bat_idx;
        n_vac_idx  = r_vac_idx;
        if (fire) begin
            case (r_in_data.op)
                OP_TICK: begin
                    if (r_counting) begin
                        if (r_counter == 16'hFFFF) begin
                            // overflow: engine stalled, stop and disarm
                            n_counting = 1'b0;
                            n_counter  = '0;
                            n_coil     = 1'b0;
                            n_armed    = 1'b0;
                        end else begin
                            n_counter = cnt_inc;
                            if (r_armed) begin
                                if (cnt_inc == r_charge) begin
                                    n_coil = 1'b1;
                                end
                                // spark wins a tie with the charge point
                                if (cnt_inc == r_spark) begin
                                    n_coil = 1'b0;
                                end
                            end
                        end
                    end
                end
                OP_TRIGGER: begin
                    n_capture  = r_counter;
                    n_counter  = '0;
                    n_counting = 1'b1;
                    n_coil     = 1'b0;
                    n_armed    = in_window;
                    if (in_window) begin
                        n_spark  = spark_calc;
                        n_charge = charge_calc;
                    end
                end
                OP_BATTERY: n_bat_idx = sample_idx;
                OP_VACUUM:  n_vac_idx = sample_idx;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_counting <= 1'b0;
            r_armed    <= 1'b0;
            r_coil     <= 1'b0;
            r_spark    <= '0;
            r_charge   <= '0;
            r_capture  <= '0;
            r_bat_idx  <= '0;
            r_vac_idx  <= '0;
        end else begin
            r_counter  <= n_counter;
            r_counting <= n_counting;
            r_armed    <= n_armed;
            r_coil     <= n_coil;
            r_spark    <= n_spark;
            r_charge   <= n_charge;
            r_capture  <= n_capture;
            r_bat_idx  <= n_bat_idx;
            r_vac_idx  <= n_vac_idx;
        end
    end

    // ------------------------------------------------------------------
    // Result register: the state as it stands after the item.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data.coil_drive     <= n_coil;
            r_out_data.cycle_valid    <= n_armed;
            r_out_data.captured_cycle <= n_capture;
            r_out_data.spark_time     <= n_spark;
            r_out_data.charge_time    <= n_charge;
        end
    end

`ifndef SYNTHESIS
    // The coil only charges from an armed compare on a running counter.
    a_coil_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coil |-> (r_armed && r_counting))
        else $error("coil on without armed compares or running counter");

    // A stopped counter always rests at zero.
    a_stopped_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_counting |-> (r_counter == 16'd0))
        else $error("counter nonzero while stopped");

    // A processed item always lands in the result register.
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed item lost before the result register");

    // A waiting item is held while the result side is blocked.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |=> r_in_valid)
        else $error("waiting item dropped under output stall");

    // State changes only when an item is processed.
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!fire && $past(i_rst_n)) |=> ($stable(r_counter) && $stable(r_coil)))
        else $error("timer state moved without an item");
`endif

endmodule
